// File: rtl/nrmc_pkg.sv
// Shared types, character codes and the time weight table for the RMC parser.
// Depends on nothing; every other file imports it.
`default_nettype none

package nrmc_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;

    localparam logic [3:0] DATE_COMMA_INDEX = 4'd9;
    localparam logic [4:0] POS_MAX          = 5'd31;
    localparam logic [3:0] COMMA_MAX        = 4'd15;
    localparam logic [4:0] TIME_FIRST_POS   = 5'd7;
    localparam logic [4:0] TIME_LAST_POS    = 5'd14;
    localparam logic [2:0] DATE_LEN         = 3'd6;

    // byte class decided in the front end
    typedef enum logic [1:0] {
        K_DOLLAR = 2'd0,
        K_EOL    = 2'd1,
        K_STAR   = 2'd2,
        K_OTHER  = 2'd3
    } byte_kind_t;

    // checksum digit tracking
    typedef enum logic [3:0] {
        PH_BODY    = 4'b0001,
        PH_HIGH    = 4'b0010,
        PH_LOW_OK  = 4'b0100,
        PH_LOW_BAD = 4'b1000
    } hex_phase_t;

    typedef struct packed {
        byte_kind_t  kind;
        logic [7:0]  byte_val;
        logic [8:0]  digit;     // byte minus '0', two's complement
        logic        hex_ok;    // upper-case hex digit
        logic [3:0]  hex_val;
    } fq_word_t;

    // weights of positions 7..14 in tenths of a second
    function automatic logic [18:0] time_weight(input logic [2:0] k);
        logic [18:0] w;
        case (k)
            3'd0:    w = 19'd360000;
            3'd1:    w = 19'd36000;
            3'd2:    w = 19'd6000;
            3'd3:    w = 19'd600;
            3'd4:    w = 19'd100;
            3'd5:    w = 19'd10;
            3'd6:    w = 19'd0;
            default: w = 19'd1;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/nrmc_front.sv
// Front end: accepts stream bytes and registers them with their class and digit values.
// Depends on nrmc_pkg.
`default_nettype none

module nrmc_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         in_byte,
    output logic                    push_valid,
    input  wire logic               push_ready,
    output nrmc_pkg::fq_word_t      push_word
);
    import nrmc_pkg::*;

    logic     f_valid_reg;
    logic     f_valid_next;
    fq_word_t f_word_reg;
    fq_word_t f_word_next;

    always_comb
    begin
        f_word_next.byte_val = in_byte;
        f_word_next.digit    = {1'b0, in_byte} - {1'b0, CH_ZERO};
        if (in_byte == CH_DOLLAR)
            f_word_next.kind = K_DOLLAR;
        else if (in_byte == CH_CR || in_byte == CH_LF)
            f_word_next.kind = K_EOL;
        else if (in_byte == CH_STAR)
            f_word_next.kind = K_STAR;
        else
            f_word_next.kind = K_OTHER;
        if (in_byte >= CH_ZERO && in_byte <= CH_NINE)
        begin
            f_word_next.hex_ok  = 1'b1;
            f_word_next.hex_val = 4'(in_byte - CH_ZERO);
        end
        else if (in_byte >= CH_UA && in_byte <= CH_UF)
        begin
            f_word_next.hex_ok  = 1'b1;
            f_word_next.hex_val = 4'(in_byte - CH_UA + 8'd10);
        end
        else
        begin
            f_word_next.hex_ok  = 1'b0;
            f_word_next.hex_val = 4'd0;
        end
    end

    assign in_ready     = !f_valid_reg || push_ready;
    assign f_valid_next = (in_valid && in_ready) ? 1'b1 :
                          (push_ready ? 1'b0 : f_valid_reg);
    assign push_valid   = f_valid_reg;
    assign push_word    = f_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else
            f_valid_reg <= f_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            f_word_reg <= f_word_next;
    end

endmodule

`default_nettype wire

// File: rtl/nrmc_queue.sv
// Two-word queue between the front end and the sentence engine.
// Depends on nrmc_pkg for the word type.
`default_nettype none

module nrmc_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_valid,
    output logic                     wr_ready,
    input  wire nrmc_pkg::fq_word_t  wr_word,
    output logic                     rd_valid,
    input  wire logic                rd_ready,
    output nrmc_pkg::fq_word_t       rd_word
);
    import nrmc_pkg::*;

    fq_word_t   mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_word  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 2'd1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_word;
    end

endmodule

`default_nettype wire

// File: rtl/nrmc_back.sv
// Sentence engine: checksum, position/comma counting, time and date capture,
// and the registered result. Depends on nrmc_pkg.
`default_nettype none

module nrmc_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    output logic                     q_ready,
    input  wire nrmc_pkg::fq_word_t  q_word,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     crc_ok,
    output logic                     date_found,
    output logic [6:0]               year_two_digit,
    output logic [6:0]               month_value,
    output logic [6:0]               day_value,
    output logic [6:0]               hour_value,
    output logic [6:0]               minute_value,
    output logic [6:0]               second_value,
    output logic [21:0]              day_tenths
);
    import nrmc_pkg::*;

    logic        in_sentence_reg, in_sentence_next;
    logic [4:0]  position_reg, position_next;
    logic [3:0]  comma_reg, comma_next;
    logic [2:0]  date_index_reg, date_index_next;
    logic [7:0]  xor_reg, xor_next;
    hex_phase_t  phase_reg, phase_next;
    logic [3:0]  high_nibble_reg, high_nibble_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;
    logic [21:0] tenths_reg, tenths_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  year_reg, year_next;
    logic        date_done_reg, date_done_next;

    logic        out_valid_reg, out_valid_next;
    logic        crc_ok_reg;
    logic        date_found_reg;
    logic [6:0]  year_out_reg, month_out_reg, day_out_reg;
    logic [6:0]  hour_out_reg, minute_out_reg, second_out_reg;
    logic [21:0] tenths_out_reg;

    logic        take;
    logic        emit;
    logic        emit_ok;
    logic [4:0]  pos_inc;
    logic [2:0]  k;
    logic [6:0]  d7;
    logic [6:0]  d7x10;
    logic [21:0] d22;
    logic [21:0] prod;

    assign take    = q_valid && (!out_valid_reg || out_ready);
    assign q_ready = take;

    assign pos_inc = (position_reg == POS_MAX) ? position_reg : position_reg + 5'd1;
    assign k       = 3'(pos_inc - TIME_FIRST_POS);
    assign d7      = q_word.digit[6:0];
    assign d7x10   = 7'(d7 * 7'd10);
    assign d22     = {{13{q_word.digit[8]}}, q_word.digit};
    assign prod    = 22'(d22 * {3'b000, time_weight(k)});

    always_comb
    begin
        in_sentence_next = in_sentence_reg;
        position_next    = position_reg;
        comma_next       = comma_reg;
        date_index_next  = date_index_reg;
        xor_next         = xor_reg;
        phase_next       = phase_reg;
        high_nibble_next = high_nibble_reg;
        hour_next        = hour_reg;
        minute_next      = minute_reg;
        second_next      = second_reg;
        tenths_next      = tenths_reg;
        day_next         = day_reg;
        month_next       = month_reg;
        year_next        = year_reg;
        date_done_next   = date_done_reg;
        emit             = 1'b0;
        emit_ok          = 1'b0;

        if (take)
        begin
            if (q_word.kind == K_DOLLAR)
            begin
                in_sentence_next = 1'b1;
                position_next    = 5'd0;
                comma_next       = 4'd0;
                date_index_next  = 3'd0;
                xor_next         = 8'd0;
                phase_next       = PH_BODY;
                high_nibble_next = 4'd0;
                hour_next        = 7'd0;
                minute_next      = 7'd0;
                second_next      = 7'd0;
                tenths_next      = 22'd0;
                day_next         = 7'd0;
                month_next       = 7'd0;
                year_next        = 7'd0;
                date_done_next   = 1'b0;
            end
            else if (in_sentence_reg)
            begin
                if (q_word.kind == K_EOL)
                    emit = 1'b1;
                else
                begin
                    case (phase_reg)
                        PH_BODY:
                        begin
                            if (q_word.kind == K_STAR)
                                phase_next = PH_HIGH;
                            else
                            begin
                                xor_next      = xor_reg ^ q_word.byte_val;
                                position_next = pos_inc;
                                if (pos_inc >= TIME_FIRST_POS && pos_inc <= TIME_LAST_POS)
                                begin
                                    tenths_next = tenths_reg + prod;
                                    case (k)
                                        3'd0: hour_next   = d7x10;
                                        3'd1: hour_next   = hour_reg + d7;
                                        3'd2: minute_next = d7x10;
                                        3'd3: minute_next = minute_reg + d7;
                                        3'd4: second_next = d7x10;
                                        3'd5: second_next = second_reg + d7;
                                        default: ;
                                    endcase
                                end
                                if (comma_reg >= DATE_COMMA_INDEX && date_index_reg < DATE_LEN)
                                begin
                                    case (date_index_reg)
                                        3'd0: day_next   = d7x10;
                                        3'd1: day_next   = day_reg + d7;
                                        3'd2: month_next = d7x10;
                                        3'd3: month_next = month_reg + d7;
                                        3'd4: year_next  = d7x10;
                                        default: year_next = year_reg + d7;
                                    endcase
                                    date_index_next = date_index_reg + 3'd1;
                                    if (date_index_reg == DATE_LEN - 3'd1)
                                        date_done_next = 1'b1;
                                end
                                if (q_word.byte_val == CH_COMMA && comma_reg != COMMA_MAX)
                                    comma_next = comma_reg + 4'd1;
                            end
                        end
                        PH_HIGH:
                        begin
                            if (q_word.hex_ok)
                            begin
                                high_nibble_next = q_word.hex_val;
                                phase_next       = PH_LOW_OK;
                            end
                            else
                                phase_next = PH_LOW_BAD;
                        end
                        PH_LOW_OK:
                        begin
                            emit    = 1'b1;
                            emit_ok = q_word.hex_ok &&
                                      ({high_nibble_reg, q_word.hex_val} == xor_reg);
                        end
                        default:
                            emit = 1'b1;
                    endcase
                end
                if (emit)
                begin
                    in_sentence_next = 1'b0;
                    phase_next       = PH_BODY;
                end
            end
        end
    end

    assign out_valid_next = (take && emit) ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sentence_reg <= 1'b0;
            position_reg    <= 5'd0;
            comma_reg       <= 4'd0;
            date_index_reg  <= 3'd0;
            xor_reg         <= 8'd0;
            phase_reg       <= PH_BODY;
            high_nibble_reg <= 4'd0;
            hour_reg        <= 7'd0;
            minute_reg      <= 7'd0;
            second_reg      <= 7'd0;
            tenths_reg      <= 22'd0;
            day_reg         <= 7'd0;
            month_reg       <= 7'd0;
            year_reg        <= 7'd0;
            date_done_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            in_sentence_reg <= in_sentence_next;
            position_reg    <= position_next;
            comma_reg       <= comma_next;
            date_index_reg  <= date_index_next;
            xor_reg         <= xor_next;
            phase_reg       <= phase_next;
            high_nibble_reg <= high_nibble_next;
            hour_reg        <= hour_next;
            minute_reg      <= minute_next;
            second_reg      <= second_next;
            tenths_reg      <= tenths_next;
            day_reg         <= day_next;
            month_reg       <= month_next;
            year_reg        <= year_next;
            date_done_reg   <= date_done_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result register, loaded only when a sentence closes
    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            crc_ok_reg     <= emit_ok;
            date_found_reg <= date_done_reg;
            year_out_reg   <= date_done_reg ? year_reg : 7'd0;
            month_out_reg  <= date_done_reg ? month_reg : 7'd0;
            day_out_reg    <= date_done_reg ? day_reg : 7'd0;
            hour_out_reg   <= hour_reg;
            minute_out_reg <= minute_reg;
            second_out_reg <= second_reg;
            tenths_out_reg <= tenths_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign crc_ok         = crc_ok_reg;
    assign date_found     = date_found_reg;
    assign year_two_digit = year_out_reg;
    assign month_value    = month_out_reg;
    assign day_value      = day_out_reg;
    assign hour_value     = hour_out_reg;
    assign minute_value   = minute_out_reg;
    assign second_value   = second_out_reg;
    assign day_tenths     = tenths_out_reg;

    a_dollar_opens: assert property (@(posedge clk) disable iff (!rst_n)
        (take && q_word.kind == K_DOLLAR) |=> (in_sentence_reg && position_reg == 5'd0))
        else $error("dollar did not open a sentence");

    a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (take && emit) |=> (out_valid_reg && !in_sentence_reg && phase_reg == PH_BODY))
        else $error("closing word did not produce a result");

    a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !in_sentence_reg |-> (phase_reg == PH_BODY))
        else $error("checksum phase active outside a sentence");

    a_date_done: assert property (@(posedge clk) disable iff (!rst_n)
        date_done_reg |-> (date_index_reg == DATE_LEN))
        else $error("date flagged before six date bytes");

endmodule

`default_nettype wire

// File: rtl/nmea_rmc_time_checksum_parser.sv
// Top level of the NMEA RMC time/date/checksum parser.
// Depends on nrmc_pkg, nrmc_front, nrmc_queue and nrmc_back.
//
// Usage:
//   Input channel (in_valid/in_ready/in_byte) takes one ASCII byte per word,
//   typically straight from a UART receiver. A '$' opens a sentence; bytes
//   outside a sentence are dropped. Output channel (out_valid/out_ready and
//   the result fields) delivers one word per sentence, when the second
//   checksum digit after '*' arrives or when CR/LF ends the sentence early
//   (then crc_ok is 0).
//   Throughput: one byte per cycle while the result slot is free or being
//   taken. Every byte costs a single pass through the sentence engine, whose
//   one multiply-add for the time weight sets the critical path.
//   A closing byte passes the front register and the queue; the result
//   register then loads the result and raises out_valid.
//   Reset: rst_n is asynchronous, active low; it empties the front register
//   and queue and clears all sentence state, so the block waits for '$'.
//   Stall: a waiting result holds in its register; the engine keeps eating
//   bytes that do not close a sentence only if the result slot is free or
//   being taken, otherwise the queue and front register absorb up to three
//   bytes before in_ready drops.
`default_nettype none

module nmea_rmc_time_checksum_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             crc_ok,
    output logic             date_found,
    output logic [6:0]       year_two_digit,
    output logic [6:0]       month_value,
    output logic [6:0]       day_value,
    output logic [6:0]       hour_value,
    output logic [6:0]       minute_value,
    output logic [6:0]       second_value,
    output logic [21:0]      day_tenths
);
    import nrmc_pkg::*;

    // front end -> queue
    logic     push_valid;
    logic     push_ready;
    fq_word_t push_word;

    // queue -> engine
    logic     q_valid;
    logic     q_ready;
    fq_word_t q_word;

    nrmc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    nrmc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_word  (push_word),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_word  (q_word)
    );

    // engine with the registered result slot
    nrmc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_word         (q_word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .crc_ok         (crc_ok),
        .date_found     (date_found),
        .year_two_digit (year_two_digit),
        .month_value    (month_value),
        .day_value      (day_value),
        .hour_value     (hour_value),
        .minute_value   (minute_value),
        .second_value   (second_value),
        .day_tenths     (day_tenths)
    );

endmodule

`default_nettype wire

// File: bench/nmea_rmc_time_checksum_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for nmea_rmc_time_checksum_parser: directed bytes, then random RMC traffic.
// Depends on nrmc_pkg and the parser RTL; results are checked against a byte-level tracker below.
module nmea_rmc_time_checksum_parser_tb;
    import nrmc_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1100;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned CYCLE_LIMIT  = 300000;

    // directed row check code: predicted, or typed fix with all fields zero and crc_ok as given
    localparam logic [1:0] PREDICT   = 2'b00;
    localparam logic [1:0] WANT_BAD  = 2'b10;
    localparam logic [1:0] WANT_GOOD = 2'b11;

    typedef struct packed {
        logic        crc_ok;
        logic        date_found;
        logic [6:0]  year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [21:0] tenths;
    } rmc_fix_t;

    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] check;
    } probe_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte   = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        crc_ok;
    logic        date_found;
    logic [6:0]  year_two_digit;
    logic [6:0]  month_value;
    logic [6:0]  day_value;
    logic [6:0]  hour_value;
    logic [6:0]  minute_value;
    logic [6:0]  second_value;
    logic [21:0] day_tenths;

    nmea_rmc_time_checksum_parser dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .crc_ok         (crc_ok),
        .date_found     (date_found),
        .year_two_digit (year_two_digit),
        .month_value    (month_value),
        .day_value      (day_value),
        .hour_value     (hour_value),
        .minute_value   (minute_value),
        .second_value   (second_value),
        .day_tenths     (day_tenths)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Sentence tracker: mirrors the parser one accepted byte at a time.
    // ------------------------------------------------------------------
    logic [21:0] TENTHS_WEIGHT [0:7] = '{22'd360000, 22'd36000, 22'd6000, 22'd600,
                                         22'd100, 22'd10, 22'd0, 22'd1};

    logic        rmc_active;
    logic [4:0]  rmc_pos;
    logic [3:0]  rmc_commas;
    logic [2:0]  rmc_date_idx;
    logic [7:0]  rmc_xor;
    hex_phase_t  rmc_hex;
    logic [3:0]  rmc_hi_nib;
    logic [6:0]  rmc_hour, rmc_minute, rmc_second;
    logic [21:0] rmc_tenths;
    logic [6:0]  rmc_day, rmc_month, rmc_year;
    logic        rmc_date_done;

    rmc_fix_t    fix_q [$];         // fixes still owed by the parser
    int unsigned sent_items = 0;    // every byte sent in the random part
    int unsigned errors     = 0;
    int unsigned cycles     = 0;
    int unsigned tx_idle_pct = 36;
    int unsigned rx_idle_pct = 61;

    function automatic void clear_tracker();
        rmc_active    = 1'b0;
        rmc_pos       = '0;
        rmc_commas    = '0;
        rmc_date_idx  = '0;
        rmc_xor       = '0;
        rmc_hex       = PH_BODY;
        rmc_hi_nib    = '0;
        rmc_hour      = '0;
        rmc_minute    = '0;
        rmc_second    = '0;
        rmc_tenths    = '0;
        rmc_day       = '0;
        rmc_month     = '0;
        rmc_year      = '0;
        rmc_date_done = 1'b0;
    endfunction

    // 0..15 for upper-case hex, bit 4 set for anything else
    function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
        if (ch >= CH_ZERO && ch <= CH_NINE)
            return {1'b0, ch[3:0]};
        if (ch >= CH_UA && ch <= CH_UF)
            return 5'(ch - CH_UA + 8'd10);
        return 5'h10;
    endfunction

    function automatic void close_fix(input logic ok, output rmc_fix_t fix);
        fix.crc_ok     = ok;
        fix.date_found = rmc_date_done;
        fix.year       = rmc_date_done ? rmc_year  : 7'd0;
        fix.month      = rmc_date_done ? rmc_month : 7'd0;
        fix.day        = rmc_date_done ? rmc_day   : 7'd0;
        fix.hour       = rmc_hour;
        fix.minute     = rmc_minute;
        fix.second     = rmc_second;
        fix.tenths     = rmc_tenths;
        rmc_active     = 1'b0;
        rmc_hex        = PH_BODY;
    endfunction

    // returns 1 when the byte closes a sentence and fills fix
    function automatic bit parse_byte(input logic [7:0] ch, output rmc_fix_t fix);
        logic [4:0]  nib;
        logic [6:0]  d7;
        logic [21:0] d22;
        logic [2:0]  k;
        fix = '0;
        d7  = ch[6:0] - 7'h30;          // digit value, no validation, wraps
        d22 = {14'd0, ch} - 22'h30;
        if (ch == CH_DOLLAR)
        begin
            clear_tracker();
            rmc_active = 1'b1;
            return 1'b0;
        end
        if (!rmc_active)
            return 1'b0;
        if (ch == CH_CR || ch == CH_LF)
        begin
            close_fix(1'b0, fix);
            return 1'b1;
        end
        case (rmc_hex)
            PH_BODY:
            begin
                if (ch == CH_STAR)
                begin
                    rmc_hex = PH_HIGH;
                    return 1'b0;
                end
                rmc_xor = rmc_xor ^ ch;
                if (rmc_pos != POS_MAX)
                    rmc_pos = rmc_pos + 5'd1;
                if (rmc_pos >= TIME_FIRST_POS && rmc_pos <= TIME_LAST_POS)
                begin
                    k = 3'(rmc_pos - TIME_FIRST_POS);
                    rmc_tenths = rmc_tenths + d22 * TENTHS_WEIGHT[k];
                    case (k)
                        3'd0: rmc_hour   = d7 * 7'd10;
                        3'd1: rmc_hour   = rmc_hour + d7;
                        3'd2: rmc_minute = d7 * 7'd10;
                        3'd3: rmc_minute = rmc_minute + d7;
                        3'd4: rmc_second = d7 * 7'd10;
                        3'd5: rmc_second = rmc_second + d7;
                        default: ;
                    endcase
                end
                // date bytes follow the ninth comma, commas included
                if (rmc_commas >= DATE_COMMA_INDEX && rmc_date_idx < DATE_LEN)
                begin
                    case (rmc_date_idx)
                        3'd0: rmc_day   = d7 * 7'd10;
                        3'd1: rmc_day   = rmc_day + d7;
                        3'd2: rmc_month = d7 * 7'd10;
                        3'd3: rmc_month = rmc_month + d7;
                        3'd4: rmc_year  = d7 * 7'd10;
                        default: rmc_year = rmc_year + d7;
                    endcase
                    rmc_date_idx = rmc_date_idx + 3'd1;
                    if (rmc_date_idx == DATE_LEN)
                        rmc_date_done = 1'b1;
                end
                if (ch == CH_COMMA && rmc_commas != COMMA_MAX)
                    rmc_commas = rmc_commas + 4'd1;
                return 1'b0;
            end
            PH_HIGH:
            begin
                nib = hex_nibble(ch);
                if (nib[4])
                    rmc_hex = PH_LOW_BAD;
                else
                begin
                    rmc_hi_nib = nib[3:0];
                    rmc_hex    = PH_LOW_OK;
                end
                return 1'b0;
            end
            default:
            begin
                nib = hex_nibble(ch);
                close_fix(rmc_hex == PH_LOW_OK && !nib[4] &&
                          {rmc_hi_nib, nib[3:0]} == rmc_xor, fix);
                return 1'b1;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Random sentence builder
    // ------------------------------------------------------------------
    logic [7:0] plan [$];
    logic [7:0] plan_sum;
    bit         plan_in_body;

    function automatic void add_char(input logic [7:0] ch);
        plan.push_back(ch);
        if (plan_in_body)
            plan_sum = plan_sum ^ ch;
    endfunction

    // any byte that does not change the sentence framing
    function automatic logic [7:0] junk_byte();
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(0, 255));
        while (ch == CH_DOLLAR || ch == CH_STAR || ch == CH_CR || ch == CH_LF);
        return ch;
    endfunction

    function automatic logic [7:0] smudge(input logic [7:0] ch);
        return ($urandom_range(0, 99) < 5) ? junk_byte() : ch;
    endfunction

    function automatic void add_two(input int unsigned v);
        add_char(smudge(CH_ZERO + 8'(v / 10)));
        add_char(smudge(CH_ZERO + 8'(v % 10)));
    endfunction

    // free text field: mostly digits and dots, some junk
    function automatic void add_free(input int unsigned max_len);
        int unsigned n;
        int unsigned r;
        n = $urandom_range(0, max_len);
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                add_char(CH_ZERO + 8'($urandom_range(0, 9)));
            else if (r < 90)
                add_char(".");
            else
                add_char(junk_byte());
        end
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? CH_ZERO + {4'd0, n} : CH_UA + {4'd0, n} - 8'd10;
    endfunction

    task automatic plan_sentence();
        int unsigned kind;
        int unsigned cut;
        int unsigned n;
        int unsigned hh, mm, ss, tt, dd, mo, yy;
        logic [7:0]  date6 [0:5];
        logic [7:0]  sum;
        logic [7:0]  hi_c, lo_c;
        plan.delete();
        plan_sum     = 8'h00;
        plan_in_body = 1'b0;
        kind = $urandom_range(0, 99);
        if (kind >= 95)
        begin
            // line noise: any byte at all, may open or close a sentence
            n = $urandom_range(1, 8);
            repeat (n) plan.push_back(8'($urandom_range(0, 255)));
            return;
        end
        plan.push_back(CH_DOLLAR);
        plan_in_body = 1'b1;
        add_char("G");
        add_char($urandom_range(0, 1) ? "P" : "N");
        add_char("R");
        add_char("M");
        add_char("C");
        add_char(CH_COMMA);
        // HHMMSS.S lands on positions 7..14
        if ($urandom_range(0, 99) < 85)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                hh = 23; mm = 59; ss = 59; tt = 9;
            end
            else
            begin
                hh = $urandom_range(0, 23);
                mm = $urandom_range(0, 59);
                ss = $urandom_range(0, 59);
                tt = $urandom_range(0, 9);
            end
            add_two(hh);
            add_two(mm);
            add_two(ss);
            add_char(smudge("."));
            add_char(smudge(CH_ZERO + 8'(tt)));
        end
        else
            add_free(10);
        add_char(CH_COMMA);
        add_char($urandom_range(0, 1) ? "A" : "V");
        add_char(CH_COMMA);
        add_free(9);
        add_char(CH_COMMA);
        add_char($urandom_range(0, 1) ? "N" : "S");
        add_char(CH_COMMA);
        add_free(10);
        add_char(CH_COMMA);
        add_char($urandom_range(0, 1) ? "E" : "W");
        add_char(CH_COMMA);
        add_free(5);
        add_char(CH_COMMA);
        add_free(5);
        add_char(CH_COMMA);             // ninth comma: date follows
        case ($urandom_range(0, 9))
            0:
            begin
                dd = 31; mo = 12; yy = 99;
            end
            1:
            begin
                dd = 1;  mo = 1;  yy = 0;
            end
            default:
            begin
                dd = $urandom_range(1, 31);
                mo = $urandom_range(1, 12);
                yy = $urandom_range(0, 99);
            end
        endcase
        date6[0] = smudge(CH_ZERO + 8'(dd / 10));
        date6[1] = smudge(CH_ZERO + 8'(dd % 10));
        date6[2] = smudge(CH_ZERO + 8'(mo / 10));
        date6[3] = smudge(CH_ZERO + 8'(mo % 10));
        date6[4] = smudge(CH_ZERO + 8'(yy / 10));
        date6[5] = smudge(CH_ZERO + 8'(yy % 10));
        // short date: star arrives before six date bytes
        n = (kind >= 70 && kind < 78) ? $urandom_range(0, 5) : 6;
        for (int i = 0; i < n; i++)
            add_char(date6[i]);
        if (n == 6)
        begin
            add_char(CH_COMMA);
            add_free(4);
            add_char(CH_COMMA);
            if ($urandom_range(0, 1))
                add_char("W");
            add_char(CH_COMMA);
            add_char("A");
        end
        // long sentence: push commas past saturation
        if (kind >= 84 && kind < 90)
        begin
            n = $urandom_range(4, 12);
            repeat (n)
            begin
                add_char(CH_COMMA);
                add_free(3);
            end
        end
        plan_in_body = 1'b0;
        add_char(CH_STAR);
        sum = plan_sum;
        if (kind >= 40 && kind < 48)
            sum = sum ^ 8'($urandom_range(1, 255));
        hi_c = hex_char(sum[7:4]);
        lo_c = hex_char(sum[3:0]);
        if (kind >= 48 && kind < 52)
        begin
            // lower-case hex: refused, digits are unaffected
            hi_c = hi_c | 8'h20;
            lo_c = lo_c | 8'h20;
        end
        else if (kind >= 52 && kind < 56)
        begin
            if ($urandom_range(0, 1))
                hi_c = junk_byte();
            else
                lo_c = junk_byte();
        end
        add_char(hi_c);
        add_char(lo_c);
        if ($urandom_range(0, 99) < 80)
        begin
            add_char(CH_CR);
            add_char(CH_LF);
        end
        // early end by CR/LF, or cut off and restarted by the next '$'
        if ((kind >= 78 && kind < 84) || (kind >= 90 && kind < 95))
        begin
            cut = $urandom_range(1, plan.size() - 1);
            while (plan.size() > cut)
                void'(plan.pop_back());
            if (kind < 84)
                plan.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        end
    endtask

    // ------------------------------------------------------------------
    // Input side: one word per call, optional idle cycles first.
    // Entered and left at a falling edge.
    // ------------------------------------------------------------------
    task automatic put_byte(input logic [7:0] ch, input logic [1:0] check);
        rmc_fix_t fix;
        bit       closes;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= ch;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_items++;
        closes = parse_byte(ch, fix);
        if (closes)
        begin
            if (check[1])
            begin
                fix        = '0;
                fix.crc_ok = check[0];
            end
            fix_q.push_back(fix);
        end
        @(negedge clk);
    endtask

    task automatic flag_mismatch(input string what, input logic [21:0] seen_v,
                                 input logic [21:0] want_v);
        $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, seen_v, want_v);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure, and the result checker.
    // ------------------------------------------------------------------
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    always @(posedge clk)
    begin : check_fix
        rmc_fix_t seen;
        rmc_fix_t want;
        if (out_valid && out_ready)
        begin
            seen = {crc_ok, date_found, year_two_digit, month_value, day_value,
                    hour_value, minute_value, second_value, day_tenths};
            if (fix_q.size() == 0)
                flag_mismatch("unexpected word", seen.tenths, 22'd0);
            else
            begin
                want = fix_q.pop_front();
                if (seen.crc_ok !== want.crc_ok)
                    flag_mismatch("crc_ok", 22'(seen.crc_ok), 22'(want.crc_ok));
                if (seen.date_found !== want.date_found)
                    flag_mismatch("date_found", 22'(seen.date_found), 22'(want.date_found));
                if (seen.year !== want.year)
                    flag_mismatch("year_two_digit", 22'(seen.year), 22'(want.year));
                if (seen.month !== want.month)
                    flag_mismatch("month_value", 22'(seen.month), 22'(want.month));
                if (seen.day !== want.day)
                    flag_mismatch("day_value", 22'(seen.day), 22'(want.day));
                if (seen.hour !== want.hour)
                    flag_mismatch("hour_value", 22'(seen.hour), 22'(want.hour));
                if (seen.minute !== want.minute)
                    flag_mismatch("minute_value", 22'(seen.minute), 22'(want.minute));
                if (seen.second !== want.second)
                    flag_mismatch("second_value", 22'(seen.second), 22'(want.second));
                if (seen.tenths !== want.tenths)
                    flag_mismatch("day_tenths", seen.tenths, want.tenths);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL nmea_rmc_time_checksum_parser");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed bytes. Typed rows expect every field zero, crc_ok as shown.
    // ------------------------------------------------------------------
    probe_t probes [0:26] = '{
        {CH_CR,     PREDICT},       // stray bytes before any '$' are dropped
        {"A",       PREDICT},
        {CH_DOLLAR, PREDICT},
        {CH_LF,     WANT_BAD},      // empty sentence ended by LF
        {CH_DOLLAR, PREDICT},
        {CH_STAR,   PREDICT},
        {"0",       PREDICT},
        {"0",       WANT_GOOD},     // empty body sums to 00
        {CH_DOLLAR, PREDICT},
        {CH_STAR,   PREDICT},
        {"G",       PREDICT},       // non-hex high digit
        {"0",       WANT_BAD},
        {CH_DOLLAR, PREDICT},
        {8'hFF,     PREDICT},       // byte extremes in the body
        {8'h00,     PREDICT},
        {CH_STAR,   PREDICT},
        {"F",       PREDICT},
        {"F",       WANT_GOOD},
        {CH_DOLLAR, PREDICT},
        {8'h80,     PREDICT},
        {CH_DOLLAR, PREDICT},       // restart throws the 0x80 away
        {CH_STAR,   PREDICT},
        {"a",       PREDICT},       // lower-case hex is refused
        {"0",       WANT_BAD},
        {CH_DOLLAR, PREDICT},
        {CH_STAR,   PREDICT},
        {CH_CR,     WANT_BAD}       // CR between star and digits
    };

    initial
    begin : stimulus
        int unsigned third;
        clear_tracker();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (probes[i])
            put_byte(probes[i].ch, probes[i].check);

        // random part: sender/receiver idle mix changes by thirds, last third runs flat out
        third = RANDOM_ITEMS / 3;
        sent_items = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            if (sent_items < third)
            begin
                tx_idle_pct = 36;
                rx_idle_pct = 61;
            end
            else if (sent_items < 2 * third)
            begin
                tx_idle_pct = 61;
                rx_idle_pct = 36;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            plan_sentence();
            foreach (plan[i])
                put_byte(plan[i], PREDICT);
        end
        in_valid <= 1'b0;

        while (fix_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS nmea_rmc_time_checksum_parser");
        else
            $display("FAIL nmea_rmc_time_checksum_parser");
        $finish;
    end

endmodule
